/* design/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared codes and character constants for the Playfair 10x10 digraph unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  // Field widths of the stream payloads.
  localparam int MODE_W     = 3;
  localparam int CHAR_W     = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int NUM_CHARS  = 1 << CHAR_W;

  // Operation codes carried in the input tuser field.
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_KEY     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FINISH  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ENCRYPT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DECRYPT = 3'd4;

  // Characters with a special meaning.
  localparam logic [CHAR_W-1:0] CHAR_PAD        = 7'h78;
  localparam logic [CHAR_W-1:0] CHAR_SPACE      = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_SEMI       = 7'h3B;
  localparam logic [CHAR_W-1:0] CHAR_DOT        = 7'h2E;
  localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 7'd32;
  localparam logic [CHAR_W-1:0] LAST_PRINTABLE  = 7'd126;

  typedef logic [CHAR_W-1:0] char_t;

  // Characters that never enter the key grid.
  function automatic logic is_excluded(input char_t c);
    return (c == CHAR_SPACE) || (c == CHAR_SEMI) || (c == CHAR_DOT);
  endfunction

endpackage

`default_nettype wire

/* design/pfc_ram.sv */
// ----------------------------------------------------------------------------
// pfc_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/pfc_step_unit.sv */
// ----------------------------------------------------------------------------
// pfc_step_unit
// Shared cell address unit: applies the row, column or rectangle rule to one
// character of a pair and returns the linear grid address of its substitute.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_step_unit #(
  parameter int GRID_SIDE = 10,
  localparam int RW       = $clog2(GRID_SIDE),
  localparam int CELLS    = GRID_SIDE * GRID_SIDE,
  localparam int CW       = $clog2(CELLS)
) (
  input  wire logic          encrypt,
  input  wire logic [RW-1:0] own_row,
  input  wire logic [RW-1:0] own_col,
  input  wire logic [RW-1:0] oth_row,
  input  wire logic [RW-1:0] oth_col,
  output logic      [CW-1:0] cell_addr
);

  localparam logic [RW-1:0] LAST_IDX = RW'(GRID_SIDE - 1);

  logic [RW-1:0] row_sel;
  logic [RW-1:0] col_sel;
  logic [CW-1:0] row_ext;

  // Move one place along a row or column, wrapping at the grid edge.
  function automatic logic [RW-1:0] wrap_step(input logic [RW-1:0] x, input logic fwd);
    logic [RW-1:0] res;
    if (fwd) begin
      res = (x == LAST_IDX) ? '0 : x + RW'(1);
    end else begin
      res = (x == '0) ? LAST_IDX : x - RW'(1);
    end
    return res;
  endfunction

  // Same row wins over same column, as for a doubled character.
  always_comb begin
    if (own_row == oth_row) begin
      row_sel = own_row;
      col_sel = wrap_step(own_col, encrypt);
    end else if (own_col == oth_col) begin
      row_sel = wrap_step(own_row, encrypt);
      col_sel = own_col;
    end else begin
      row_sel = own_row;
      col_sel = oth_col;
    end
  end

  // Linear cell number: row times the grid side plus column.
  assign row_ext   = CW'(row_sel);
  assign cell_addr = row_ext * CW'(GRID_SIDE) + CW'(col_sel);

endmodule

`default_nettype wire

/* design/playfair_digraph_cipher_10x10_unit.sv */
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_10x10_unit
// Playfair digraph cipher over a GRID_SIDE x GRID_SIDE grid of 7-bit codes.
// ----------------------------------------------------------------------------
// The unit takes one beat at a time and is not ready while a beat is in
// work. A clear or a key character completes in the accepting cycle, so the
// next beat can follow right away. A finish beat walks the 95 printable codes
// one per cycle and keeps the input closed until the walk ends. An encrypt
// or decrypt beat holds the input closed through RDA, RDB, LDB, GR1, GR2 and
// DONE, which waits for a free output register: the two position lookups and
// the two grid reads each go through a single registered read port, with one
// shared address unit forming both grid addresses. Finished results sit in an
// output register, so a new beat is taken while the last result still waits.
// Reset clears the key state; no memory clearing pass is needed.
`default_nettype none

module playfair_digraph_cipher_10x10_unit
  import pfc_pkg::*;
#(
  parameter int GRID_SIDE = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // tdata: first_char[6:0], second_char[13:7], second_present[14], zero fill
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: mode[2:0]
  input  wire logic [MODE_W-1:0]     in_tuser,
  // tlast: last_pair
  input  wire logic                  in_tlast,
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // tdata: out_first[6:0], out_second[13:7], zero fill
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // tuser: second_valid
  output logic                       out_tuser,
  // tlast: end_of_message
  output logic                       out_tlast
);

  localparam int RW    = $clog2(GRID_SIDE);
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CW    = $clog2(CELLS);
  localparam int FW    = $clog2(CELLS + 1);
  localparam logic [RW-1:0] LAST_IDX = RW'(GRID_SIDE - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIN  = 3'd1;
  localparam logic [2:0] S_RDA  = 3'd2;
  localparam logic [2:0] S_RDB  = 3'd3;
  localparam logic [2:0] S_LDB  = 3'd4;
  localparam logic [2:0] S_GR1  = 3'd5;
  localparam logic [2:0] S_GR2  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [NUM_CHARS-1:0] used_r, used_nxt;
  logic [FW-1:0]        fill_idx_r, fill_idx_nxt;
  logic [RW-1:0]        fill_row_r, fill_row_nxt;
  logic [RW-1:0]        fill_col_r, fill_col_nxt;
  char_t                fin_c_r, fin_c_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Pair payload registers.
  char_t         a_r, b_r;
  logic          enc_r, last_r;
  logic [RW-1:0] ra_r, ca_r, rb_r, cb_r;
  char_t         o1_r;
  logic          cv_r;
  char_t         out_first_r, out_second_r;
  logic          out_sv_r, out_last_r;

  logic          in_acc;
  char_t         in_first, in_second;
  logic          in_present;
  char_t         place_c;
  logic          place_en, place_ok, grid_full;

  logic [2*RW-1:0] pos_rdata;
  char_t           pos_raddr;
  char_t           grid_rdata;
  logic [CW-1:0]   grid_raddr;
  logic            sel_second;
  logic [RW-1:0]   own_row, own_col, oth_row, oth_col;
  logic            cell_valid;
  logic            out_load;
  char_t           o2_raw;
  logic            drop_pad;

  assign in_first   = in_tdata[CHAR_W-1:0];
  assign in_second  = in_tdata[2*CHAR_W-1:CHAR_W];
  assign in_present = in_tdata[2*CHAR_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Key placement: one character per cycle from a key beat or the finish walk.
  assign grid_full = (fill_idx_r == FW'(CELLS));
  assign place_c   = (state_r == S_FIN) ? fin_c_r : in_first;
  assign place_en  = (state_r == S_FIN) || (in_acc && in_tuser == MODE_KEY);
  assign place_ok  = place_en && !used_r[place_c] && !is_excluded(place_c) && !grid_full;

  // Character to {row, col} lookup; entries without a used bit read as cell 0.
  assign pos_raddr = (state_r == S_RDA) ? a_r : b_r;

  pfc_ram #(
    .WIDTH (2 * RW),
    .DEPTH (NUM_CHARS)
  ) u_pos_ram (
    .clk   (clk),
    .we    (place_ok),
    .waddr (place_c),
    .wdata ({fill_row_r, fill_col_r}),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // Key grid; cells at or above the fill count read as zero.
  pfc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (place_ok),
    .waddr (fill_idx_r[CW-1:0]),
    .wdata (place_c),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  // Shared address unit, first for the first character, then for the second.
  assign sel_second = (state_r != S_GR1);
  assign own_row    = sel_second ? rb_r : ra_r;
  assign own_col    = sel_second ? cb_r : ca_r;
  assign oth_row    = sel_second ? ra_r : rb_r;
  assign oth_col    = sel_second ? ca_r : cb_r;

  pfc_step_unit #(
    .GRID_SIDE (GRID_SIDE)
  ) u_step (
    .encrypt   (enc_r),
    .own_row   (own_row),
    .own_col   (own_col),
    .oth_row   (oth_row),
    .oth_col   (oth_col),
    .cell_addr (grid_raddr)
  );

  assign cell_valid = (FW'(grid_raddr) < fill_idx_r);

  // Result formation, with the trailing pad dropped on a final decrypted pair.
  assign o2_raw   = cv_r ? grid_rdata : '0;
  assign drop_pad = !enc_r && last_r && (o2_raw == CHAR_PAD);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Sequencer and key state.
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    fill_idx_nxt  = fill_idx_r;
    fill_row_nxt  = fill_row_r;
    fill_col_nxt  = fill_col_r;
    fin_c_nxt     = fin_c_r;
    out_valid_nxt = out_valid_r;

    if (place_ok) begin
      used_nxt[place_c] = 1'b1;
      fill_idx_nxt      = fill_idx_r + FW'(1);
      if (fill_col_r == LAST_IDX) begin
        fill_col_nxt = '0;
        fill_row_nxt = (fill_row_r == LAST_IDX) ? '0 : fill_row_r + RW'(1);
      end else begin
        fill_col_nxt = fill_col_r + RW'(1);
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            MODE_CLEAR: begin
              used_nxt     = '0;
              fill_idx_nxt = '0;
              fill_row_nxt = '0;
              fill_col_nxt = '0;
            end
            MODE_FINISH: begin
              fin_c_nxt = FIRST_PRINTABLE;
              state_nxt = S_FIN;
            end
            MODE_ENCRYPT, MODE_DECRYPT: begin
              state_nxt = S_RDA;
            end
            default: begin
            end
          endcase
        end
      end
      S_FIN: begin
        fin_c_nxt = fin_c_r + CHAR_W'(1);
        if (fin_c_r == LAST_PRINTABLE) begin
          state_nxt = S_IDLE;
        end
      end
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_LDB;
      S_LDB:  state_nxt = S_GR1;
      S_GR1:  state_nxt = S_GR2;
      S_GR2:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Output register handshake.
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      fill_idx_r  <= '0;
      fill_row_r  <= '0;
      fill_col_r  <= '0;
      fin_c_r     <= FIRST_PRINTABLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_idx_r  <= fill_idx_nxt;
      fill_row_r  <= fill_row_nxt;
      fill_col_r  <= fill_col_nxt;
      fin_c_r     <= fin_c_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pair datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r    <= in_first;
      b_r    <= in_present ? in_second : CHAR_PAD;
      enc_r  <= (in_tuser == MODE_ENCRYPT);
      last_r <= in_tlast;
    end
    if (state_r == S_RDB) begin
      ra_r <= used_r[a_r] ? pos_rdata[2*RW-1:RW] : '0;
      ca_r <= used_r[a_r] ? pos_rdata[RW-1:0]    : '0;
    end
    if (state_r == S_LDB) begin
      rb_r <= used_r[b_r] ? pos_rdata[2*RW-1:RW] : '0;
      cb_r <= used_r[b_r] ? pos_rdata[RW-1:0]    : '0;
    end
    if (state_r == S_GR1 || state_r == S_GR2) begin
      cv_r <= cell_valid;
    end
    if (state_r == S_GR2) begin
      o1_r <= cv_r ? grid_rdata : '0;
    end
    if (out_load) begin
      out_first_r  <= o1_r;
      out_second_r <= drop_pad ? '0 : o2_raw;
      out_sv_r     <= !drop_pad;
      out_last_r   <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - 2 * CHAR_W)'(0), out_second_r, out_first_r};
  assign out_tuser  = out_sv_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* design/pfc_checker.sv */
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level assertions for the Playfair unit, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_checker
  import pfc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [MODE_W-1:0]     in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser,
  input wire logic                  out_tlast
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // A waiting result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // A pair beat closes the input for its lookups.
  a_pair_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == MODE_ENCRYPT || in_tuser == MODE_DECRYPT) |=> !in_tready)
    else $error("input reopened during pair lookup");

  // Clear and key beats finish in the accepting cycle.
  a_key_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == MODE_CLEAR || in_tuser == MODE_KEY) |=> in_tready)
    else $error("input not ready after clear or key beat");

  // A dropped second character reads as zero and only on a final pair.
  a_drop_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata[13:7] == 7'd0))
    else $error("dropped pad on a non-final pair or with nonzero data");

  // A result never appears in the cycle right after a pair beat is taken.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == MODE_ENCRYPT || in_tuser == MODE_DECRYPT) && !out_tvalid
      |=> !out_tvalid)
    else $error("result appeared before lookups completed");

endmodule

bind playfair_digraph_cipher_10x10_unit pfc_checker u_pfc_checker (.*);

`default_nettype wire

/* bench/playfair_digraph_cipher_10x10_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_10x10_unit_tb
// Self-checking bench for the Playfair 10x10 digraph unit. A scoreboard
// class keeps its own key grid and reverse table, predicts every cipher
// result from the beats that the unit accepts, and compares each result beat
// field by field. Stimulus starts with a directed set and then runs random
// key/message sequences mixed with noise, with random idling on both streams,
// one long output stall and a few pauses until all results have come.
// ----------------------------------------------------------------------------

module playfair_digraph_cipher_10x10_unit_tb;
  import pfc_pkg::*;

  localparam int SIDE              = 10;
  localparam int CELLS             = SIDE * SIDE;
  localparam int RANDOM_ITEMS      = 1650;
  localparam int CYCLE_LIMIT       = 800000;
  localparam int END_WAIT          = 5000;
  localparam int DRAIN_CYCLES      = 30;
  localparam int STALL_SEQ         = 30;
  localparam int LONG_STALL_CYCLES = 400;

  typedef logic [MODE_W-1:0] mode_t;

  // Lowest operation code that the unit ignores; the codes above it are
  // ignored as well.
  localparam mode_t MODE_SPARE = 3'd5;

  typedef struct {
    mode_t mode;
    char_t first;
    char_t second;
    logic  has_second;
    logic  last;
  } pair_item_t;

  typedef struct {
    char_t first;
    char_t second;
    logic  second_ok;
    logic  end_msg;
  } cipher_out_t;

  // Key grid predictor plus the queue of cipher results still to come.
  class cipher_scoreboard;
    char_t       grid_cells[CELLS];
    int unsigned cell_of[NUM_CHARS];
    bit          placed[NUM_CHARS];
    int unsigned fill_count;
    cipher_out_t expected_q[$];
    int unsigned mismatches, checked;
    int unsigned n_clear, n_key, n_finish, n_enc, n_dec, n_ignored, n_refused, n_dropped;

    function new();
      clear_key();
    endfunction

    function void clear_key();
      foreach (grid_cells[i]) grid_cells[i] = '0;
      foreach (cell_of[i]) begin
        cell_of[i] = 0;
        placed[i]  = 1'b0;
      end
      fill_count = 0;
    endfunction

    // Space, semicolon and dot never enter the grid.
    function bit kept_out(char_t c);
      return (c == CHAR_SPACE) || (c == CHAR_SEMI) || (c == CHAR_DOT);
    endfunction

    function void place_key(char_t c);
      if (placed[c] || kept_out(c)) return;
      if (fill_count >= CELLS) begin
        n_refused++;
        return;
      end
      grid_cells[fill_count] = c;
      cell_of[c]             = fill_count;
      placed[c]              = 1'b1;
      fill_count++;
    endfunction

    function char_t grid_at(int unsigned row, int unsigned col);
      return grid_cells[(row % SIDE) * SIDE + (col % SIDE)];
    endfunction

    // Playfair transform of one pair under the current key.
    function cipher_out_t cipher_pair(mode_t mode, char_t a, char_t b, logic has_b, logic last);
      cipher_out_t r;
      int unsigned ra, ca, rb, cb, sh;
      if (!has_b) b = CHAR_PAD;
      ra = (cell_of[a] % CELLS) / SIDE;
      ca = cell_of[a] % SIDE;
      rb = (cell_of[b] % CELLS) / SIDE;
      cb = cell_of[b] % SIDE;
      sh = (mode == MODE_ENCRYPT) ? 1 : SIDE - 1;
      if (ra == rb) begin
        r.first  = grid_at(ra, ca + sh);
        r.second = grid_at(rb, cb + sh);
      end else if (ca == cb) begin
        r.first  = grid_at(ra + sh, ca);
        r.second = grid_at(rb + sh, cb);
      end else begin
        r.first  = grid_at(ra, cb);
        r.second = grid_at(rb, ca);
      end
      r.second_ok = 1'b1;
      r.end_msg   = last;
      // A padding x at the end of a decrypted message is dropped.
      if (mode == MODE_DECRYPT && last && r.second == CHAR_PAD) begin
        r.second_ok = 1'b0;
        r.second    = '0;
      end
      return r;
    endfunction

    // Apply one accepted input beat to the predicted state.
    function void note(pair_item_t it);
      cipher_out_t res;
      case (it.mode)
        MODE_CLEAR: begin
          clear_key();
          n_clear++;
        end
        MODE_KEY: begin
          place_key(it.first);
          n_key++;
        end
        MODE_FINISH: begin
          for (int c = FIRST_PRINTABLE; c <= LAST_PRINTABLE; c++) place_key(char_t'(c));
          n_finish++;
        end
        MODE_ENCRYPT, MODE_DECRYPT: begin
          res = cipher_pair(it.mode, it.first, it.second, it.has_second, it.last);
          expected_q.insert(expected_q.size(), res);
          if (it.mode == MODE_ENCRYPT) n_enc++;
          else n_dec++;
          if (!res.second_ok) n_dropped++;
        end
        default: n_ignored++;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what, int unsigned want, int unsigned got);
      $display("MISMATCH at result %0d: %s expected 0x%0h, got 0x%0h", checked, what, want, got);
      mismatches++;
    endtask

    // Compare one accepted result beat with the oldest prediction.
    task check(logic [OUT_DATA_W-1:0] data, logic sec_ok, logic lst);
      cipher_out_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected, tdata", 0, data);
        return;
      end
      want = expected_q.pop_front();
      if (data[6:0] !== want.first) report_mismatch("out_first", want.first, data[6:0]);
      if (data[13:7] !== want.second) report_mismatch("out_second", want.second, data[13:7]);
      if (sec_ok !== want.second_ok) report_mismatch("second_valid", want.second_ok, sec_ok);
      if (lst !== want.end_msg) report_mismatch("end_of_message", want.end_msg, lst);
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [MODE_W-1:0]     in_tuser   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  cipher_scoreboard sb = new();
  int unsigned      cycle_count = 0;
  int unsigned      items_sent  = 0;
  bit               tx_burst    = 1'b0;
  bit               rx_burst    = 1'b0;
  bit               stall_request = 1'b0;
  bit               stall_done    = 1'b0;

  playfair_digraph_cipher_10x10_unit #(
    .GRID_SIDE(SIDE)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped by the watchdog after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic char_t rand_char();
    return char_t'($urandom_range(0, NUM_CHARS - 1));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Message characters come mostly from the current grid.
  function automatic char_t message_char();
    if (sb.fill_count > 0 && $urandom_range(0, 3) != 0)
      return sb.grid_cells[$urandom_range(0, sb.fill_count - 1)];
    return rand_char();
  endfunction

  // Offer one input beat after a random gap and hold it until it is taken.
  task automatic offer(mode_t mode, char_t a, char_t b, logic has_b, logic last);
    pair_item_t  it;
    int unsigned gap;
    it.mode       = mode;
    it.first      = a;
    it.second     = b;
    it.has_second = has_b;
    it.last       = last;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, has_b, b, a};
    in_tuser  <= mode;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note(it);
    if (mode <= MODE_DECRYPT) items_sent++;
  endtask

  // Drop the input and wait until every predicted result has arrived.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Result side: random hold-off before each beat, one long stall on request.
  initial begin : result_sink
    int unsigned hold;
    int unsigned rx_beats;
    rx_beats = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_beats % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (stall_request && !stall_done) begin
        hold       = LONG_STALL_CYCLES;
        stall_done = 1'b1;
      end else if (rx_burst) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 9);
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check(out_tdata, out_tuser, out_tlast);
      rx_beats++;
    end
  end

  initial begin : stimulus
    cipher_out_t ct;
    int unsigned seq, pick, nkeys, npairs, start, target, waited;
    mode_t       msg_mode;
    char_t       p1, p2;
    logic        has_b, last;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Pairs on an empty grid: every character is unmapped.
    offer(MODE_ENCRYPT, char_t'("A"), char_t'("B"), 1'b1, 1'b0);
    offer(MODE_DECRYPT, '0, '1, 1'b0, 1'b1);

    // Key with a duplicate, the three skipped characters and both extremes.
    offer(MODE_CLEAR, '1, '1, 1'b1, 1'b1);
    offer(MODE_KEY, char_t'("P"), '0, 1'b0, 1'b0);
    offer(MODE_KEY, char_t'("L"), '0, 1'b0, 1'b0);
    offer(MODE_KEY, char_t'("A"), '0, 1'b0, 1'b0);
    offer(MODE_KEY, char_t'("Y"), '0, 1'b0, 1'b0);
    offer(MODE_KEY, char_t'("F"), '0, 1'b0, 1'b0);
    offer(MODE_KEY, char_t'("A"), '0, 1'b0, 1'b0);
    offer(MODE_KEY, CHAR_SPACE, '0, 1'b0, 1'b0);
    offer(MODE_KEY, CHAR_SEMI, '0, 1'b0, 1'b0);
    offer(MODE_KEY, CHAR_DOT, '0, 1'b0, 1'b0);
    offer(MODE_KEY, '0, '1, 1'b1, 1'b1);
    offer(MODE_KEY, '1, '0, 1'b0, 1'b0);
    offer(MODE_FINISH, '0, '0, 1'b0, 1'b0);

    // Row shift wrapping at the right edge, column shift wrapping at the
    // top, rectangle swap and a pair of equal letters.
    offer(MODE_ENCRYPT, char_t'("F"), char_t'("#"), 1'b1, 1'b0);
    offer(MODE_DECRYPT, char_t'("P"), char_t'("$"), 1'b1, 1'b0);
    offer(MODE_ENCRYPT, char_t'("L"), char_t'("$"), 1'b1, 1'b0);
    offer(MODE_ENCRYPT, char_t'("A"), char_t'("A"), 1'b1, 1'b0);

    // Missing second character on encrypt and on decrypt.
    offer(MODE_ENCRYPT, char_t'("Q"), '1, 1'b0, 1'b1);
    offer(MODE_DECRYPT, char_t'("K"), '0, 1'b0, 1'b0);

    // Last pair of a decrypted message that ends in the padding x.
    ct = sb.cipher_pair(MODE_ENCRYPT, char_t'("H"), CHAR_PAD, 1'b1, 1'b0);
    offer(MODE_DECRYPT, ct.first, ct.second, 1'b1, 1'b1);

    // Unused operation codes.
    offer(MODE_SPARE, '1, '1, 1'b1, 1'b1);
    offer(MODE_SPARE + 3'd1, '0, '1, 1'b0, 1'b1);
    offer(MODE_SPARE + 3'd2, '1, '0, 1'b1, 1'b0);
    wait_for_results();

    // Random part: key/message sequences, full-range keys and noise.
    target = items_sent + RANDOM_ITEMS;
    seq    = 0;
    while (items_sent < target) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      if (seq == STALL_SEQ) begin
        stall_request = 1'b1;
        tx_burst      = 1'b1;
      end
      // The stall sequence always carries a full message.
      pick = (seq == STALL_SEQ) ? 50 : $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4))
          offer(mode_t'($urandom_range(0, 7)), rand_char(), rand_char(), rand_bit(), rand_bit());
      end else begin
        if (pick < 11) begin
          // Every code as a key character: the grid fills and the rest saturate.
          offer(MODE_CLEAR, rand_char(), rand_char(), rand_bit(), rand_bit());
          start = $urandom_range(0, NUM_CHARS - 1);
          for (int i = 0; i < NUM_CHARS; i++)
            offer(MODE_KEY, char_t'((start + i) % NUM_CHARS), rand_char(), rand_bit(),
                  rand_bit());
        end else begin
          if ($urandom_range(0, 9) != 0)
            offer(MODE_CLEAR, rand_char(), rand_char(), rand_bit(), rand_bit());
          nkeys = $urandom_range(0, 12);
          repeat (nkeys)
            offer(MODE_KEY, ($urandom_range(0, 5) == 0) ? rand_char() :
                  char_t'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE)),
                  rand_char(), rand_bit(), rand_bit());
          if ($urandom_range(0, 6) != 0)
            offer(MODE_FINISH, rand_char(), rand_char(), rand_bit(), rand_bit());
        end

        // One message under the new key.
        msg_mode = rand_bit() ? MODE_ENCRYPT : MODE_DECRYPT;
        npairs   = (seq == STALL_SEQ) ? 8 : $urandom_range(1, 8);
        for (int i = 0; i < npairs; i++) begin
          last  = (i == npairs - 1);
          p1    = message_char();
          p2    = message_char();
          has_b = ($urandom_range(0, 6) != 0);
          if (msg_mode == MODE_DECRYPT && last && $urandom_range(0, 2) == 0) begin
            ct    = sb.cipher_pair(MODE_ENCRYPT, p1, CHAR_PAD, 1'b1, 1'b0);
            p1    = ct.first;
            p2    = ct.second;
            has_b = 1'b1;
          end
          offer(msg_mode, p1, p2, has_b, last);
        end
      end
      if (seq != STALL_SEQ && $urandom_range(0, 9) == 0) wait_for_results();
      seq++;
    end

    // Let the last results come out, then watch for stray beats.
    in_tvalid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("results never delivered, count", 0, sb.pending());

    $write("Covered %0d encrypt and %0d decrypt pairs (%0d trailing pads dropped), ",
           sb.n_enc, sb.n_dec, sb.n_dropped);
    $display("%0d key beats, %0d finishes, %0d clears.", sb.n_key, sb.n_finish, sb.n_clear);
    $write("%0d key characters refused by a full grid, %0d unused-code beats, ",
           sb.n_refused, sb.n_ignored);
    $display("%0d results checked, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
